// File: src/nbsm_pkg.sv
// Shared types and constants for the NIC buffer slot manager.
`default_nettype none
package nbsm_pkg;

  localparam int CMD_W      = 2;
  localparam int HEAD_W     = 8;
  localparam int RXB_W      = 6;
  localparam int LEN_W      = 13;
  localparam int ST_W       = 3;
  localparam int CNT_W      = 7;
  localparam int CTR_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CMD_W-1:0] CMD_TX_CLAIM    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TX_COMPLETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RX_USED     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RX_POP      = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_RX_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_SLOT  = 3'd3;
  localparam logic [ST_W-1:0] ST_SUBMIT   = 3'd4;
  localparam logic [ST_W-1:0] ST_DEFER    = 3'd5;
  localparam logic [ST_W-1:0] ST_BAD_HEAD = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_CONSUMER_LIVE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_BUFFER_COUNT = 1'd1;

  localparam logic [CNT_W-1:0] RX_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } rem_req_t;

endpackage
`default_nettype wire

// File: src/nic_buffer_slot_manager.sv
// Top level: receive staging ring and transmit slot allocator.
//
// Usage: one command word enters on in_* (valid/stall) and exactly one result
// word leaves on out_* (valid/stall). Each item has an accept cycle and an
// update cycle: the accept cycle issues reads of the staging ring RAM and the
// head map RAM, the update cycle modifies and writes them back and loads the
// output register. Result valid rises at the edge that ends the update cycle.
// A new item is accepted once the last has left its update cycle, also while
// a result still waits; its update cycle holds until the output register is
// taken. Counters and high_water on the result ports belong to the result
// currently shown. Config writes use cfg_valid/cfg_ready and are to be made
// while idle; the block itself does not enforce this. Writing rx_buffer_count
// renormalizes the ring head with cfg_ready and input acceptance held off.
// Reset: synchronous on rst_n low. Afterwards the head map RAM is cleared,
// one entry a cycle, while in_stall stays high.
// The staging ring RAM is not cleared.
`default_nettype none
module nic_buffer_slot_manager
  import nbsm_pkg::*;
#(
  parameter int RX_DEPTH     = 64,
  parameter int TX_SLOTS     = 16,
  parameter int HEAD_ENTRIES = 256,
  parameter int MAX_FRAME    = 1514,
  parameter int HEADER_BYTES = 12,
  localparam int TX_W = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1,
  localparam int FL_W = $clog2(MAX_FRAME + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [HEAD_W-1:0]     in_desc_head,
  input  logic                  in_submit_ok,
  input  logic [RXB_W-1:0]      in_rx_buffer,
  input  logic [LEN_W-1:0]      in_rx_length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ST_W-1:0]       out_status,
  output logic [TX_W-1:0]       out_tx_slot,
  output logic [RXB_W-1:0]      out_rx_slot,
  output logic [FL_W-1:0]       out_frame_length,
  output logic                  out_repost,
  output logic                  out_wake,
  output logic [CTR_W-1:0]      out_tx_frames,
  output logic [CTR_W-1:0]      out_rx_frames,
  output logic [CTR_W-1:0]      out_tx_drops,
  output logic [CTR_W-1:0]      out_rx_drops,
  output logic [CNT_W-1:0]      out_high_water,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RX_AW  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int HM_AW  = (HEAD_ENTRIES > 1) ? $clog2(HEAD_ENTRIES) : 1;
  localparam int SLOT_W = $clog2(TX_SLOTS + 1);
  localparam int RING_W = RXB_W + LEN_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [HEAD_W-1:0] head_r;
  logic              submit_r;
  logic [RXB_W-1:0]  rxbuf_r;
  logic [LEN_W-1:0]  rxlen_r;

  logic             live_r;
  logic [CNT_W-1:0] count_cfg_r;
  logic [CNT_W-1:0] n_eff;

  // ring_head_r keeps the head as last set by a pop; ring_pos_r is it modulo the ring size
  logic [CNT_W-1:0] ring_head_r, ring_head_nxt;
  logic [CNT_W-1:0] ring_pos_r, ring_pos_nxt;
  logic [CNT_W-1:0] ring_count_r, ring_count_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;
  logic [TX_SLOTS-1:0] slot_busy_r, slot_busy_nxt;
  logic [CTR_W-1:0] tx_frames_r, rx_frames_r, tx_drops_r, rx_drops_r;
  logic             inc_tx_frames, inc_rx_frames, inc_tx_drops, inc_rx_drops;

  logic             clr_r;
  logic [HM_AW-1:0] clr_idx_r;

  logic             red_pend_r;
  logic             red_busy;
  rem_req_t         rem_req;
  logic             rem_busy;
  logic             rem_done;
  logic [CNT_W-1:0] rem_result;

  logic in_acc;
  logic cfg_acc;
  logic exec_go;

  logic              map_we_c;
  logic [SLOT_W-1:0] map_wdata_c;
  logic              map_we;
  logic [HM_AW-1:0]  map_waddr;
  logic [SLOT_W-1:0] map_wdata;
  logic [SLOT_W-1:0] map_rd;

  logic              ring_we_c;
  logic [CNT_W-1:0]  ring_tail;
  logic [RING_W-1:0] ring_rd;

  logic [TX_W-1:0] free_idx;
  logic            free_found;
  logic            head_oor;
  logic [CNT_W:0]  tail_sum;
  logic [CNT_W:0]  head_inc;
  logic [LEN_W:0]  flen_wide;

  logic [ST_W-1:0]  status_c;
  logic [TX_W-1:0]  tx_slot_c;
  logic [RXB_W-1:0] rx_slot_c;
  logic [FL_W-1:0]  flen_c;
  logic             repost_c;
  logic             wake_c;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [TX_W-1:0]  out_tx_slot_r;
  logic [RXB_W-1:0] out_rx_slot_r;
  logic [FL_W-1:0]  out_flen_r;
  logic             out_repost_r;
  logic             out_wake_r;

  assign red_busy  = red_pend_r | rem_busy;
  assign in_stall  = clr_r | red_busy | (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = ~red_busy;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign exec_go   = (state_r == S_EXEC) & (~out_valid_r | ~out_stall);

  always_comb begin
    if (count_cfg_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(count_cfg_r) > 32'(RX_DEPTH)) begin
      n_eff = CNT_W'(RX_DEPTH);
    end else begin
      n_eff = count_cfg_r;
    end
  end

  // lowest free transmit slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = TX_SLOTS - 1; i >= 0; i--) begin
      if (!slot_busy_r[i]) begin
        free_idx   = TX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign head_oor  = 32'(head_r) >= 32'(HEAD_ENTRIES);
  assign tail_sum  = {1'b0, ring_pos_r} + {1'b0, ring_count_r};
  assign ring_tail = (tail_sum >= {1'b0, n_eff}) ? CNT_W'(tail_sum - {1'b0, n_eff})
                                                 : tail_sum[CNT_W-1:0];
  assign head_inc  = {1'b0, ring_pos_r} + 1'b1;

  always_comb begin
    if (ring_rd[LEN_W-1:0] > LEN_W'(HEADER_BYTES)) begin
      flen_wide = {1'b0, ring_rd[LEN_W-1:0] - LEN_W'(HEADER_BYTES)};
    end else begin
      flen_wide = '0;
    end
  end

  always_comb begin
    status_c       = ST_OK;
    tx_slot_c      = '0;
    rx_slot_c      = '0;
    flen_c         = '0;
    repost_c       = 1'b0;
    wake_c         = 1'b0;
    map_we_c       = 1'b0;
    map_wdata_c    = '0;
    ring_we_c      = 1'b0;
    slot_busy_nxt  = slot_busy_r;
    ring_head_nxt  = ring_head_r;
    ring_pos_nxt   = ring_pos_r;
    ring_count_nxt = ring_count_r;
    peak_nxt       = peak_r;
    inc_tx_frames  = 1'b0;
    inc_rx_frames  = 1'b0;
    inc_tx_drops   = 1'b0;
    inc_rx_drops   = 1'b0;
    unique case (cmd_r)
      CMD_TX_CLAIM: begin
        if (!free_found) begin
          status_c     = ST_NO_SLOT;
          inc_tx_drops = 1'b1;
        end else if (!submit_r) begin
          status_c     = ST_SUBMIT;
          inc_tx_drops = 1'b1;
        end else if (head_oor || map_rd != '0) begin
          status_c = ST_BAD_HEAD;
        end else begin
          slot_busy_nxt[free_idx] = 1'b1;
          map_we_c    = 1'b1;
          map_wdata_c = SLOT_W'(free_idx) + 1'b1;
          tx_slot_c   = free_idx;
        end
      end
      CMD_TX_COMPLETE: begin
        if (head_oor || map_rd == '0 || 32'(map_rd) > 32'(TX_SLOTS)) begin
          status_c = ST_BAD_HEAD;
        end else begin
          slot_busy_nxt[TX_W'(map_rd - 1'b1)] = 1'b0;
          map_we_c      = 1'b1;
          map_wdata_c   = '0;
          tx_slot_c     = TX_W'(map_rd - 1'b1);
          inc_tx_frames = 1'b1;
          wake_c        = 1'b1;
        end
      end
      CMD_RX_USED: begin
        if (!live_r) begin
          status_c = ST_DEFER;
        end else if ({1'b0, rxbuf_r} >= n_eff) begin
          status_c = ST_BAD_HEAD;
        end else if (ring_count_r >= n_eff) begin
          status_c     = ST_RX_FULL;
          inc_rx_drops = 1'b1;
          rx_slot_c    = rxbuf_r;
          repost_c     = 1'b1;
        end else begin
          ring_we_c      = 1'b1;
          ring_count_nxt = ring_count_r + 1'b1;
          if (ring_count_nxt > peak_r) begin
            peak_nxt = ring_count_nxt;
          end
          inc_rx_frames = 1'b1;
          wake_c        = 1'b1;
        end
      end
      CMD_RX_POP: begin
        if (ring_count_r == '0) begin
          status_c = ST_EMPTY;
        end else begin
          rx_slot_c = ring_rd[LEN_W +: RXB_W];
          if (head_inc == {1'b0, n_eff}) begin
            ring_head_nxt = '0;
          end else begin
            ring_head_nxt = head_inc[CNT_W-1:0];
          end
          ring_pos_nxt   = ring_head_nxt;
          ring_count_nxt = ring_count_r - 1'b1;
          if (flen_wide > (LEN_W + 1)'(MAX_FRAME)) begin
            flen_c = FL_W'(MAX_FRAME);
          end else begin
            flen_c = FL_W'(flen_wide);
          end
          repost_c = 1'b1;
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  assign map_we    = clr_r | (exec_go & map_we_c);
  assign map_waddr = clr_r ? clr_idx_r : HM_AW'(head_r);
  assign map_wdata = clr_r ? '0 : map_wdata_c;

  nbsm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (HEAD_ENTRIES)
  ) u_head_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (in_acc),
    .raddr (HM_AW'(in_desc_head)),
    .rdata (map_rd)
  );

  nbsm_ram #(
    .WIDTH (RING_W),
    .DEPTH (RX_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (exec_go & ring_we_c),
    .waddr (RX_AW'(ring_tail)),
    .wdata ({rxbuf_r, rxlen_r}),
    .re    (in_acc),
    .raddr (RX_AW'(ring_pos_r)),
    .rdata (ring_rd)
  );

  assign rem_req.start    = red_pend_r;
  assign rem_req.dividend = ring_head_r;
  assign rem_req.divisor  = n_eff;

  nbsm_rem u_rem (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (rem_req),
    .busy   (rem_busy),
    .done   (rem_done),
    .result (rem_result)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_cmd;
      head_r   <= in_desc_head;
      submit_r <= in_submit_ok;
      rxbuf_r  <= in_rx_buffer;
      rxlen_r  <= in_rx_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clr_r        <= 1'b1;
      clr_idx_r    <= '0;
      live_r       <= 1'b0;
      count_cfg_r  <= RX_COUNT_RESET;
      red_pend_r   <= 1'b0;
      ring_head_r  <= '0;
      ring_pos_r   <= '0;
      ring_count_r <= '0;
      peak_r       <= '0;
      slot_busy_r  <= '0;
      tx_frames_r  <= '0;
      rx_frames_r  <= '0;
      tx_drops_r   <= '0;
      rx_drops_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == HM_AW'(HEAD_ENTRIES - 1)) begin
          clr_r <= 1'b0;
        end
      end

      red_pend_r <= 1'b0;
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_CONSUMER_LIVE: begin
            live_r <= cfg_data[0];
          end
          CFG_RX_BUFFER_COUNT: begin
            count_cfg_r <= cfg_data;
            red_pend_r  <= 1'b1;
          end
          default: begin
            live_r <= live_r;
          end
        endcase
      end
      if (rem_done) begin
        ring_pos_r <= rem_result;
      end

      if (in_acc) begin
        state_r <= S_EXEC;
      end else if (exec_go) begin
        state_r <= S_IDLE;
      end

      if (exec_go) begin
        ring_head_r  <= ring_head_nxt;
        ring_pos_r   <= ring_pos_nxt;
        ring_count_r <= ring_count_nxt;
        peak_r       <= peak_nxt;
        slot_busy_r  <= slot_busy_nxt;
        tx_frames_r  <= tx_frames_r + CTR_W'(inc_tx_frames);
        rx_frames_r  <= rx_frames_r + CTR_W'(inc_rx_frames);
        tx_drops_r   <= tx_drops_r + CTR_W'(inc_tx_drops);
        rx_drops_r   <= rx_drops_r + CTR_W'(inc_rx_drops);
        out_valid_r  <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r  <= status_c;
      out_tx_slot_r <= tx_slot_c;
      out_rx_slot_r <= rx_slot_c;
      out_flen_r    <= flen_c;
      out_repost_r  <= repost_c;
      out_wake_r    <= wake_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_tx_slot      = out_tx_slot_r;
  assign out_rx_slot      = out_rx_slot_r;
  assign out_frame_length = out_flen_r;
  assign out_repost       = out_repost_r;
  assign out_wake         = out_wake_r;
  assign out_tx_frames    = tx_frames_r;
  assign out_rx_frames    = rx_frames_r;
  assign out_tx_drops     = tx_drops_r;
  assign out_rx_drops     = rx_drops_r;
  assign out_high_water   = peak_r;

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> in_stall)
    else $error("item accepted during head map clear");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC))
    else $error("accepted item did not enter update cycle");

  a_exec_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r)
    else $error("update cycle did not load a result");

  a_peak_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
    ring_count_r <= peak_r)
    else $error("ring occupancy above high-water mark");

  a_head_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (!red_busy && !clr_r) |-> (ring_pos_r < n_eff))
    else $error("ring head outside ring size");
`endif

endmodule
`default_nettype wire

// File: src/nbsm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module nbsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: src/nbsm_rem.sv
// Restoring remainder unit, one bit per cycle, for ring head renormalization.
`default_nettype none
module nbsm_rem
  import nbsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  rem_req_t         req,
  output logic             busy,
  output logic             done,
  output logic [CNT_W-1:0] result
);

  localparam int STEP_W = $clog2(CNT_W);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W-1:0]  rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[CNT_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CNT_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[CNT_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy   = busy_r;
  assign done   = busy_r && (step_r == STEP_W'(CNT_W - 1));
  assign result = rem_nxt;

endmodule
`default_nettype wire

// File: verif/tb_nic_buffer_slot_manager.sv
// Self-checking testbench for nic_buffer_slot_manager: predicts every result word and compares.
`timescale 1ns / 100ps
module tb_nic_buffer_slot_manager;
  import nbsm_pkg::*;

  localparam int RING_DEPTH     = 64;
  localparam int SLOT_COUNT     = 16;
  localparam int HEAD_COUNT     = 256;
  localparam int FRAME_MAX      = 1514;
  localparam int HDR_BYTES      = 12;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [HEAD_W-1:0] head;
    logic              submit_ok;
    logic [RXB_W-1:0]  rx_buffer;
    logic [LEN_W-1:0]  rx_length;
  } cmd_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [3:0]       tx_slot;
    logic [RXB_W-1:0] rx_slot;
    logic [10:0]      frame_length;
    logic             repost;
    logic             wake;
    logic [CTR_W-1:0] tx_frames;
    logic [CTR_W-1:0] rx_frames;
    logic [CTR_W-1:0] tx_drops;
    logic [CTR_W-1:0] rx_drops;
    logic [CNT_W-1:0] high_water;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_word_t drv_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ST_W-1:0] out_status;
  logic [3:0] out_tx_slot;
  logic [RXB_W-1:0] out_rx_slot;
  logic [10:0] out_frame_length;
  logic out_repost;
  logic out_wake;
  logic [CTR_W-1:0] out_tx_frames;
  logic [CTR_W-1:0] out_rx_frames;
  logic [CTR_W-1:0] out_tx_drops;
  logic [CTR_W-1:0] out_rx_drops;
  logic [CNT_W-1:0] out_high_water;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nic_buffer_slot_manager DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (drv_word.cmd),
    .in_desc_head     (drv_word.head),
    .in_submit_ok     (drv_word.submit_ok),
    .in_rx_buffer     (drv_word.rx_buffer),
    .in_rx_length     (drv_word.rx_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_tx_slot      (out_tx_slot),
    .out_rx_slot      (out_rx_slot),
    .out_frame_length (out_frame_length),
    .out_repost       (out_repost),
    .out_wake         (out_wake),
    .out_tx_frames    (out_tx_frames),
    .out_rx_frames    (out_rx_frames),
    .out_tx_drops     (out_tx_drops),
    .out_rx_drops     (out_rx_drops),
    .out_high_water   (out_high_water),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow bookkeeping state
  logic             live;
  logic [CNT_W-1:0] buf_count;
  logic [RXB_W-1:0] ring_buf [RING_DEPTH];
  logic [LEN_W-1:0] ring_len [RING_DEPTH];
  int               ring_head;
  int               ring_count;
  logic             slot_busy [SLOT_COUNT];
  logic [4:0]       head_map [HEAD_COUNT];
  logic [CTR_W-1:0] tx_frames, rx_frames, tx_drops, rx_drops;
  logic [CNT_W-1:0] peak;

  cmd_word_t    command_backlog [$];
  result_word_t awaited_results [$];
  logic [7:0]   claimed_heads [$];

  logic word_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   stall_span = 0;
  int   stall_tick = 0;
  int   idle_cycles = 0;
  int   words_sent = 0;
  int   results_checked = 0;
  int   mismatches = 0;
  int   status_seen [8];

  function automatic int ring_size();
    int n;
    n = buf_count;
    if (n == 0) n = 1;
    if (n > RING_DEPTH) n = RING_DEPTH;
    return n;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_CONSUMER_LIVE) live = val[0];
    else if (idx == CFG_RX_BUFFER_COUNT) buf_count = val;
  endfunction

  function automatic result_word_t book_result(cmd_word_t w);
    result_word_t r;
    int n, i, pos, tail, len, flen;
    r = '0;
    n = ring_size();
    case (w.cmd)
      CMD_TX_CLAIM: begin
        i = 0;
        while (i < SLOT_COUNT && slot_busy[i]) i++;
        if (i == SLOT_COUNT) begin
          r.status = ST_NO_SLOT;
          tx_drops++;
        end else if (!w.submit_ok) begin
          r.status = ST_SUBMIT;
          tx_drops++;
        end else if (head_map[w.head] != 0) begin
          r.status = ST_BAD_HEAD;
        end else begin
          slot_busy[i] = 1'b1;
          head_map[w.head] = 5'(i + 1);
          r.tx_slot = 4'(i);
        end
      end
      CMD_TX_COMPLETE: begin
        if (head_map[w.head] == 0 || head_map[w.head] > SLOT_COUNT) begin
          r.status = ST_BAD_HEAD;
        end else begin
          i = head_map[w.head] - 1;
          head_map[w.head] = '0;
          slot_busy[i] = 1'b0;
          tx_frames++;
          r.tx_slot = 4'(i);
          r.wake = 1'b1;
        end
      end
      CMD_RX_USED: begin
        if (!live) begin
          r.status = ST_DEFER;
        end else if (int'(w.rx_buffer) >= n) begin
          r.status = ST_BAD_HEAD;
        end else if (ring_count >= n) begin
          r.status = ST_RX_FULL;
          rx_drops++;
          r.rx_slot = w.rx_buffer;
          r.repost = 1'b1;
        end else begin
          tail = ((ring_head % n) + ring_count) % n;
          ring_buf[tail] = w.rx_buffer;
          ring_len[tail] = w.rx_length;
          ring_count++;
          if (ring_count > peak) peak = CNT_W'(ring_count);
          rx_frames++;
          r.wake = 1'b1;
        end
      end
      default: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = ring_head % n;
          len = ring_len[pos];
          flen = (len > HDR_BYTES) ? len - HDR_BYTES : 0;
          if (flen > FRAME_MAX) flen = FRAME_MAX;
          r.rx_slot = ring_buf[pos];
          r.frame_length = 11'(flen);
          r.repost = 1'b1;
          ring_head = (pos + 1) % n;
          ring_count--;
        end
      end
    endcase
    r.tx_frames = tx_frames;
    r.rx_frames = rx_frames;
    r.tx_drops = tx_drops;
    r.rx_drops = rx_drops;
    r.high_water = peak;
    return r;
  endfunction

  function automatic cmd_word_t make_word(logic [CMD_W-1:0] c, int head, int submit, int buffer,
                                          int len);
    cmd_word_t w;
    w.cmd = c;
    w.head = HEAD_W'(head);
    w.submit_ok = submit[0];
    w.rx_buffer = RXB_W'(buffer);
    w.rx_length = LEN_W'(len);
    return w;
  endfunction

  function automatic int pick_length();
    int edges [10] = '{0, 1, 11, 12, 13, 1525, 1526, 1527, 4095, 4096};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 9)];
    return $urandom_range(0, 4096);
  endfunction

  function automatic cmd_word_t noise_word(logic [CMD_W-1:0] c);
    return make_word(c, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 63),
                     pick_length());
  endfunction

  // Driver: take words, run the predictor at acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      awaited_results.push_back(book_result(drv_word));
      words_sent++;
      word_taken = 1'b1;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      apply_reg(cfg_index, cfg_data);
      cfg_taken = 1'b1;
    end
  end

  // Driver: present words in bursts with gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || word_taken)) begin
      word_taken = 1'b0;
      if (command_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (burst_left == 0 && gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        drv_word <= command_backlog.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver stall pattern
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ((stall_tick % 9) < 5);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Monitor: compare result words, watchdog
  always @(posedge clk) begin : monitor
    result_word_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_status, out_tx_slot, out_rx_slot, out_frame_length, out_repost, out_wake,
               out_tx_frames, out_rx_frames, out_tx_drops, out_rx_drops, out_high_water};
        results_checked++;
        status_seen[got.status]++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result word %0d arrived with nothing awaited", results_checked);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result word %0d mismatch", results_checked);
              $display("  exp st=%0d tx=%0d rx=%0d len=%0d rp=%0d wk=%0d ctr=%0d/%0d/%0d/%0d hw=%0d",
                       want.status, want.tx_slot, want.rx_slot, want.frame_length, want.repost,
                       want.wake, want.tx_frames, want.rx_frames, want.tx_drops, want.rx_drops,
                       want.high_water);
              $display("  got st=%0d tx=%0d rx=%0d len=%0d rp=%0d wk=%0d ctr=%0d/%0d/%0d/%0d hw=%0d",
                       got.status, got.tx_slot, got.rx_slot, got.frame_length, got.repost,
                       got.wake, got.tx_frames, got.rx_frames, got.tx_drops, got.rx_drops,
                       got.high_water);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (command_backlog.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_valid <= 1'b0;
  endtask

  // Empty the ring so a size change never exposes stale entries
  task automatic settle_and_config(logic is_live, logic [CFG_DATA_W-1:0] count);
    wait_idle();
    if (ring_count > 0) begin
      repeat (ring_count) command_backlog.push_back(noise_word(CMD_RX_POP));
      wait_idle();
    end
    write_reg(CFG_CONSUMER_LIVE, CFG_DATA_W'(is_live));
    write_reg(CFG_RX_BUFFER_COUNT, count);
  endtask

  task automatic run_phase(logic is_live, logic [CFG_DATA_W-1:0] count, int words, int w_claim,
                           int w_complete, int w_used);
    int n, k, pick, idx, chunk_left;
    cmd_word_t w;
    settle_and_config(is_live, count);
    n = (count == 0) ? 1 : ((count > RING_DEPTH) ? RING_DEPTH : count);
    chunk_left = $urandom_range(20, 70);
    for (k = 0; k < words; k++) begin
      if (chunk_left == 0) begin
        if ($urandom_range(0, 2) == 0) wait_idle();
        chunk_left = $urandom_range(20, 70);
      end
      chunk_left--;
      pick = $urandom_range(0, 99);
      if (pick < w_claim) begin
        w = noise_word(CMD_TX_CLAIM);
        w.head = ($urandom_range(0, 3) != 0) ? HEAD_W'($urandom_range(0, 23)) : w.head;
        w.submit_ok = ($urandom_range(0, 9) != 0);
        if (w.submit_ok) claimed_heads.push_back(w.head);
        if (claimed_heads.size() > 40) void'(claimed_heads.pop_front());
      end else if (pick < w_claim + w_complete) begin
        w = noise_word(CMD_TX_COMPLETE);
        if (claimed_heads.size() > 0 && $urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, claimed_heads.size() - 1);
          w.head = claimed_heads[idx];
          claimed_heads.delete(idx);
        end
      end else if (pick < w_claim + w_complete + w_used) begin
        w = noise_word(CMD_RX_USED);
        if ($urandom_range(0, 9) != 0) w.rx_buffer = RXB_W'($urandom_range(0, n - 1));
      end else begin
        w = noise_word(CMD_RX_POP);
      end
      command_backlog.push_back(w);
    end
  endtask

  initial begin
    live = 1'b0;
    buf_count = RX_COUNT_RESET;
    ring_head = 0;
    ring_count = 0;
    tx_frames = '0;
    rx_frames = '0;
    tx_drops = '0;
    rx_drops = '0;
    peak = '0;
    foreach (ring_buf[i]) begin
      ring_buf[i] = '0;
      ring_len[i] = '0;
    end
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    foreach (head_map[i]) head_map[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset config, consumer stopped
    command_backlog.push_back(make_word(CMD_RX_USED, 0, 0, 5, 100));
    command_backlog.push_back(make_word(CMD_RX_POP, 0, 0, 0, 0));
    command_backlog.push_back(make_word(CMD_TX_COMPLETE, 7, 1, 0, 0));
    command_backlog.push_back(make_word(CMD_TX_CLAIM, 0, 0, 0, 0));
    command_backlog.push_back(make_word(CMD_TX_CLAIM, 0, 1, 0, 0));
    command_backlog.push_back(make_word(CMD_TX_CLAIM, 0, 1, 0, 0));
    command_backlog.push_back(make_word(CMD_TX_CLAIM, 255, 1, 63, 8191));
    command_backlog.push_back(make_word(CMD_TX_COMPLETE, 0, 0, 0, 0));
    command_backlog.push_back(make_word(CMD_TX_CLAIM, 128, 1, 0, 0));
    command_backlog.push_back(make_word(CMD_TX_COMPLETE, 255, 1, 0, 0));
    command_backlog.push_back(make_word(CMD_TX_COMPLETE, 128, 0, 0, 0));

    // Directed: two-entry ring, consumer running
    settle_and_config(1'b1, 7'd2);
    command_backlog.push_back(make_word(CMD_RX_USED, 0, 0, 63, 100));
    command_backlog.push_back(make_word(CMD_RX_USED, 0, 0, 0, 0));
    command_backlog.push_back(make_word(CMD_RX_USED, 0, 0, 1, 4096));
    command_backlog.push_back(make_word(CMD_RX_USED, 0, 0, 1, 20));
    command_backlog.push_back(make_word(CMD_RX_POP, 0, 0, 0, 0));
    command_backlog.push_back(make_word(CMD_RX_POP, 0, 0, 0, 0));
    command_backlog.push_back(make_word(CMD_RX_USED, 0, 0, 0, 12));
    command_backlog.push_back(make_word(CMD_RX_USED, 0, 0, 1, 1526));
    command_backlog.push_back(make_word(CMD_RX_POP, 0, 0, 0, 0));
    command_backlog.push_back(make_word(CMD_RX_POP, 0, 0, 0, 0));
    command_backlog.push_back(make_word(CMD_RX_POP, 0, 0, 0, 0));
    command_backlog.push_back(make_word(CMD_RX_USED, 0, 0, 0, 13));
    command_backlog.push_back(make_word(CMD_RX_USED, 0, 0, 1, 11));
    command_backlog.push_back(make_word(CMD_RX_POP, 0, 0, 0, 0));

    // Random phases
    run_phase(1'b1, 7'd64, 200, 25, 20, 35);
    run_phase(1'b1, 7'd1, 150, 20, 15, 35);
    run_phase(1'b1, 7'd64, 220, 10, 5, 60);
    run_phase(1'b0, 7'd16, 120, 45, 15, 25);
    run_phase(1'b1, 7'd127, 150, 20, 20, 30);
    run_phase(1'b1, 7'd0, 120, 20, 20, 30);
    run_phase(1'b1, 7'd3, 150, 20, 20, 30);
    run_phase(1'b1, CFG_DATA_W'($urandom_range(2, 63)), 160, 25, 25, 25);
    run_phase(1'b1, 7'd64, 150, 15, 15, 35);

    wait_idle();
    repeat (16) @(posedge clk);
    if (awaited_results.size() != 0) mismatches++;

    $display("Sent %0d command words over 11 ring settings, checked %0d results, %0d mismatches",
             words_sent, results_checked, mismatches);
    $display("Status mix: ok %0d empty %0d full %0d no-slot %0d submit %0d deferred %0d bad %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RX_FULL],
             status_seen[ST_NO_SLOT], status_seen[ST_SUBMIT], status_seen[ST_DEFER],
             status_seen[ST_BAD_HEAD]);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: nic_buffer_slot_manager.f
src/nbsm_pkg.sv
src/nbsm_ram.sv
src/nbsm_rem.sv
src/nic_buffer_slot_manager.sv
verif/tb_nic_buffer_slot_manager.sv
